[src/aar_pkg.sv]
// Shared types, constants and helpers for the axis auto-repeat block.
// No dependencies; every other file of the block imports this package.
package aar_pkg;

  // Configuration port geometry and register widths.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned TimerW   = 32;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ElapsedW = 20;
  localparam int unsigned DirW     = 2;

  // Register reset values, all in microseconds.
  localparam logic [CfgDataW-1:0] FirstDelayRst   = 24'd500000;
  localparam logic [CfgDataW-1:0] SecondDelayRst  = 24'd2000000;
  localparam logic [CfgDataW-1:0] IntervalSlowRst = 24'd150000;
  localparam logic [CfgDataW-1:0] IntervalFastRst = 24'd50000;

  // Half scale in Q1.15; the dead zone edges themselves count as no direction.
  localparam logic signed [SampleW-1:0] HalfQ15    = 16'sd16384;
  localparam logic signed [SampleW-1:0] NegHalfQ15 = -16'sd16384;

  // Direction codes as carried on the result word.
  localparam logic [DirW-1:0] DirNone = 2'b00;
  localparam logic [DirW-1:0] DirPos  = 2'b01;
  localparam logic [DirW-1:0] DirNeg  = 2'b11;
  localparam logic [DirW-1:0] DirBad  = 2'b10;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FIRST_DELAY   = 8'd0,
    REG_SECOND_DELAY  = 8'd1,
    REG_INTERVAL_SLOW = 8'd2,
    REG_INTERVAL_FAST = 8'd3
  } cfg_reg_e;

  // Repeat stage of a hold time.
  typedef enum logic [1:0] {
    STAGE_IDLE = 2'd0,
    STAGE_SLOW = 2'd1,
    STAGE_FAST = 2'd2
  } stage_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [CfgDataW-1:0] first_delay;
    logic [CfgDataW-1:0] second_delay;
    logic [CfgDataW-1:0] interval_slow;
    logic [CfgDataW-1:0] interval_fast;
  } cfg_t;

  // Stage of a hold time against the two delays, second delay tested first.
  function automatic stage_e stage_of(input logic [TimerW-1:0] hold, input cfg_t cfg);
    stage_e st;
    if (hold > {{(TimerW-CfgDataW){1'b0}}, cfg.second_delay}) begin
      st = STAGE_FAST;
    end else if (hold > {{(TimerW-CfgDataW){1'b0}}, cfg.first_delay}) begin
      st = STAGE_SLOW;
    end else begin
      st = STAGE_IDLE;
    end
    return st;
  endfunction

  // Saturating add of an elapsed time onto a timer.
  function automatic logic [TimerW-1:0] sat_add(input logic [TimerW-1:0] a,
                                                input logic [ElapsedW-1:0] b);
    logic [TimerW:0] sum;
    sum = {1'b0, a} + {{(TimerW+1-ElapsedW){1'b0}}, b};
    return sum[TimerW] ? {TimerW{1'b1}} : sum[TimerW-1:0];
  endfunction

endpackage

[src/axis_auto_repeat.sv]
// Two-rate auto-repeat for one analog axis, one result word per sample word.
// A word passes through the input register, then the result register; a stalled result holds it in the input register.
// Throughput: one word per cycle while the result is not held, as aar_step computes its timer update combinationally.
// Reset: asynchronous active low; clears direction and timers, loads default delays.
// The input stalls only while a word waits in the input register and the result is held.
module axis_auto_repeat import aar_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SampleW-1:0]  axis_sample_i,
  input  logic [ElapsedW-1:0]        elapsed_us_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DirW-1:0]     repeat_event_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  cfg_t cfg;

  logic                      in_vld_q;
  logic signed [SampleW-1:0] sample_q;
  logic [ElapsedW-1:0]       elapsed_q;
  logic                      out_vld_q;
  logic [DirW-1:0]           event_q;
  logic [DirW-1:0]           step_event;
  logic                      out_free;
  logic                      step_fire;
  logic                      in_take;

  aar_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake glue between the input register and the result register.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step_fire  = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q  <= axis_sample_i;
      elapsed_q <= elapsed_us_i;
    end
  end

  aar_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (step_fire),
    .axis_sample_i (sample_q),
    .elapsed_us_i  (elapsed_q),
    .cfg_i         (cfg),
    .event_o       (step_event)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      event_q <= step_event;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign repeat_event_o = event_q;

`ifndef ASSERT_OFF
  // An empty input register never holds off the upstream side.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  // A word processed by the step logic always lands in the result register.
  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> out_vld_q)
    else $error("processed word did not reach the result register");

  // A delivered result is always a legal direction code.
  a_event_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (repeat_event_o != DirBad))
    else $error("illegal direction code on the result");
`endif

endmodule

[src/aar_cfg_regs.sv]
// Configuration register file of the axis auto-repeat block.
// Depends on aar_pkg for the register indexes, reset values and cfg_t.
module aar_cfg_regs import aar_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Writes are always accepted.
  assign cfg_ready_o = 1'b1;

  // Register write; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_delay   <= FirstDelayRst;
      cfg_q.second_delay  <= SecondDelayRst;
      cfg_q.interval_slow <= IntervalSlowRst;
      cfg_q.interval_fast <= IntervalFastRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FIRST_DELAY:   cfg_q.first_delay   <= cfg_data_i;
        REG_SECOND_DELAY:  cfg_q.second_delay  <= cfg_data_i;
        REG_INTERVAL_SLOW: cfg_q.interval_slow <= cfg_data_i;
        REG_INTERVAL_FAST: cfg_q.interval_fast <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/aar_step.sv]
// Per-sample auto-repeat logic: quantizer, hold timers and repeat decision.
// Depends on aar_pkg; holds the direction and timer state of the block.
module aar_step import aar_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic signed [SampleW-1:0]  axis_sample_i,
  input  logic [ElapsedW-1:0]        elapsed_us_i,
  input  cfg_t                       cfg_i,
  output logic [DirW-1:0]            event_o
);

  logic [DirW-1:0]   last_dir_q, last_dir_d;
  logic [TimerW-1:0] hold_q, hold_d;
  logic [TimerW-1:0] since_q, since_d;

  logic [DirW-1:0]     dir;
  logic                changed;
  logic [TimerW-1:0]   hold_sum;
  logic [TimerW-1:0]   since_sum;
  stage_e              prev_stage;
  stage_e              new_stage;
  logic [CfgDataW-1:0] interval;
  logic [TimerW-1:0]   interval_ext;

  // Quantize the sample with a dead zone of one half either way.
  always_comb begin
    if (axis_sample_i > HalfQ15) begin
      dir = DirPos;
    end else if (axis_sample_i < NegHalfQ15) begin
      dir = DirNeg;
    end else begin
      dir = DirNone;
    end
  end

  assign changed   = (dir != last_dir_q);
  assign hold_sum  = sat_add(hold_q, elapsed_us_i);
  assign since_sum = sat_add(since_q, elapsed_us_i);
  assign prev_stage = stage_of(hold_q, cfg_i);
  assign new_stage  = stage_of(hold_sum, cfg_i);
  assign interval     = (new_stage == STAGE_FAST) ? cfg_i.interval_fast : cfg_i.interval_slow;
  assign interval_ext = {{(TimerW-CfgDataW){1'b0}}, interval};

  // Timer update and emit decision for one sample.
  always_comb begin
    last_dir_d = dir;
    hold_d     = hold_sum;
    since_d    = since_sum;
    event_o    = changed ? dir : DirNone;
    if (dir == DirNone) begin
      hold_d  = '0;
      since_d = '0;
      event_o = DirNone;
    end else if (new_stage != prev_stage) begin
      since_d = '0;
      event_o = dir;
    end else if (new_stage != STAGE_IDLE && since_sum > interval_ext) begin
      since_d = since_sum - interval_ext;
      event_o = dir;
    end
  end

  // State advances only when a sample moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dir_q <= DirNone;
      hold_q     <= '0;
      since_q    <= '0;
    end else if (fire_i) begin
      last_dir_q <= last_dir_d;
      hold_q     <= hold_d;
      since_q    <= since_d;
    end
  end

endmodule
